// ----- hdl/tcnb_pkg.sv -----
// Shared types, widths, register indexes and reset values of the neighbour binner.
`timescale 1ns / 1ps

package tcnb_pkg;

    // field widths
    localparam int CENTER_W = 10;
    localparam int TYPE_W   = 2;
    localparam int NIDX_W   = 16;
    localparam int NID_W    = 17;
    localparam int POS_W    = 24;
    localparam int DELTA_W  = 25;
    localparam int SLOT_W   = 7;
    localparam int COUNT_W  = 8;
    localparam int CFG_SQ_W = 40;
    localparam int TMAP_W   = 8;

    // arithmetic widths
    localparam int PROD_W = 49;              // one squared delta
    localparam int RSQ_W  = 50;              // sum of three squares
    localparam int ROOT_W = CFG_SQ_W / 2;    // root of a value within the cutoff
    localparam int REM_W  = ROOT_W + 2;

    // type counters, one per model type code
    localparam int TYPE_SLOTS = 4;

    // stream widths
    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 136;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_CUTOFF   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CLOSE    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TYPE_MAP = 2'd2;

    localparam logic [CFG_SQ_W-1:0] CUTOFF_RST = 40'd603979776;
    localparam logic [CFG_SQ_W-1:0] CLOSE_RST  = 40'd13589545;   // 0.81 square Angstrom
    localparam logic [TMAP_W-1:0]   TMAP_RST   = 8'd228;         // identity map

    typedef struct packed {
        logic [CFG_SQ_W-1:0] cutoff_sq;
        logic [CFG_SQ_W-1:0] close_sq;
        logic [TMAP_W-1:0]   type_map;
    } t_cfg;

    typedef struct packed {
        logic              clear;
        logic              bump;
        logic [TYPE_W-1:0] mtype;
    } t_cnt_req;

    typedef struct packed {
        logic              grant;
        logic [SLOT_W-1:0] slot;
    } t_cnt_rsp;

endpackage

// ----- hdl/typed_cutoff_neighbor_binner.sv -----
// Top level of the typed cutoff neighbour binner: sequencer, pair registers, output stage.
`timescale 1ns / 1ps

// Each request on the input stream is one candidate pair; a pair within the cutoff gives one
// result on the output stream, others give none. The block takes one pair at a time: a pair
// within the cutoff is accepted, the shared multiplier squares and sums the three deltas, a
// compare against the cutoff follows, then the bit-serial square root runs and the result is
// loaded into the output register once that register is free. A pair beyond the cutoff ends
// at the compare and a pair whose centre index is out of range ends at its accept. A finished
// result waits in the output register while the next pair is already being worked on.
// Configuration registers sit at byte addresses 0 (cutoff_sq), 8 (close_sq) and 16
// (type_map); they are to be written only while the block is idle, and the block itself
// does not enforce this.

module typed_cutoff_neighbor_binner
    import tcnb_pkg::*;
#(
    parameter int NBR_LIMIT = 128,
    parameter int NUM_TYPES = 4,
    parameter int MAX_ATOMS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pair requests
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // center_index, center_type, neighbor_index, neighbor_type,
    // center_x, center_y, center_z, neighbor_x, neighbor_y, neighbor_z, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // first_of_center
    input  logic [0:0]            s_axis_tuser,
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_center, center_model_type, neighbor_model_type, slot, neighbor_id,
    // distance, delta_x, delta_y, delta_z, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // too_close, overflow
    output logic [1:0]            m_axis_tuser,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [NIDX_W:0] ATOM_LIMIT = (NIDX_W + 1)'(MAX_ATOMS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQ   = 5'b00010,
        S_CMP  = 5'b00100,
        S_ROOT = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    t_cfg     w_cfg;
    t_cnt_req w_cnt_req;
    t_cnt_rsp w_cnt_rsp;

    // input fields
    logic [CENTER_W-1:0]      w_center;
    logic [TYPE_W-1:0]        w_ctype;
    logic [NIDX_W-1:0]        w_nidx;
    logic [TYPE_W-1:0]        w_ntype;
    logic signed [POS_W-1:0]  w_cx, w_cy, w_cz, w_nx, w_ny, w_nz;

    logic                     w_accept;
    logic                     w_in_range;
    logic                     w_beyond;
    logic                     w_load;
    logic [RSQ_W-1:0]         w_rsq;
    logic                     w_sq_done;
    logic [ROOT_W-1:0]        w_root;
    logic                     w_root_done;

    // pair registers
    logic [CENTER_W-1:0]      r_center;
    logic [TYPE_W-1:0]        r_cmt;
    logic [TYPE_W-1:0]        r_nmt;
    logic [NID_W-1:0]         r_nid;
    logic signed [DELTA_W-1:0] r_dx, r_dy, r_dz;
    logic [SLOT_W-1:0]        r_slot;
    logic                     r_ovf;
    logic                     r_close;

    // output stage
    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;
    logic [1:0]               r_out_user;

    // unpack the request
    assign w_center = s_axis_tdata[9:0];
    assign w_ctype  = s_axis_tdata[11:10];
    assign w_nidx   = s_axis_tdata[27:12];
    assign w_ntype  = s_axis_tdata[29:28];
    assign w_cx     = s_axis_tdata[53:30];
    assign w_cy     = s_axis_tdata[77:54];
    assign w_cz     = s_axis_tdata[101:78];
    assign w_nx     = s_axis_tdata[125:102];
    assign w_ny     = s_axis_tdata[149:126];
    assign w_nz     = s_axis_tdata[173:150];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_range    = ((NIDX_W + 1)'(w_center) < ATOM_LIMIT);
    assign w_beyond      = (w_rsq > RSQ_W'(w_cfg.cutoff_sq));
    assign w_load        = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);

    // counter requests: clear on a new centre, claim a slot at the compare
    assign w_cnt_req.clear = w_accept && s_axis_tuser[0];
    assign w_cnt_req.bump  = (r_state == S_CMP) && !w_beyond;
    assign w_cnt_req.mtype = r_nmt;

    tcnb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tcnb_sqacc u_sqacc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && w_in_range),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_dz    (r_dz),
        .o_rsq   (w_rsq),
        .o_done  (w_sq_done)
    );

    tcnb_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_cnt_req.bump),
        .i_radicand (w_rsq[2*ROOT_W-1:0]),
        .o_root     (w_root),
        .o_done     (w_root_done)
    );

    tcnb_counts #(
        .NBR_LIMIT (NBR_LIMIT),
        .NUM_TYPES (NUM_TYPES)
    ) u_counts (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cnt_req),
        .o_rsp   (w_cnt_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept && w_in_range) n_state = S_SQ;
            S_SQ:   if (w_sq_done) n_state = S_CMP;
            S_CMP:  n_state = w_beyond ? S_IDLE : S_ROOT;
            S_ROOT: if (w_root_done) n_state = S_EMIT;
            S_EMIT: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture the pair, map types and form the deltas
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_center <= w_center;
            r_cmt    <= w_cfg.type_map[2*w_ctype +: TYPE_W];
            r_nmt    <= w_cfg.type_map[2*w_ntype +: TYPE_W];
            r_nid    <= NID_W'(w_nidx) + 1'b1;
            r_dx     <= DELTA_W'(w_nx) - DELTA_W'(w_cx);
            r_dy     <= DELTA_W'(w_ny) - DELTA_W'(w_cy);
            r_dz     <= DELTA_W'(w_nz) - DELTA_W'(w_cz);
        end
        if (r_state == S_CMP) begin
            r_slot  <= w_cnt_rsp.slot;
            r_ovf   <= !w_cnt_rsp.grant;
            r_close <= (w_rsq < RSQ_W'(w_cfg.close_sq));
        end
    end

    // output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {3'b000, r_dz, r_dy, r_dx, w_root, r_nid, r_slot,
                           r_nmt, r_cmt, r_center};
            r_out_user <= {r_ovf, r_close};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // a result that waits to load is in the output register on the next cycle
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && (!r_out_valid || m_axis_tready)
        |=> m_axis_tvalid && s_axis_tready)
        else $error("result not loaded after emit");

    // an overflowed pair carries slot zero
    a_ovf_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata[20:14] == '0))
        else $error("overflow result with nonzero slot");

    // a centre out of range leaves the block ready at once
    a_range_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_in_range |=> s_axis_tready)
        else $error("out of range centre started work");

    // square root only runs for a pair within the cutoff
    a_root_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> (r_state == S_ROOT) && ($past(r_state) == S_ROOT))
        else $error("square root finished outside its state");

endmodule

// ----- hdl/tcnb_regs.sv -----
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module tcnb_regs
    import tcnb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    logic                 w_write;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite;
    assign w_idx   = paddr[APB_ADDR_W-1:3];
    assign o_cfg   = r_cfg;

    // write a register at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cutoff_sq <= CUTOFF_RST;
            r_cfg.close_sq  <= CLOSE_RST;
            r_cfg.type_map  <= TMAP_RST;
        end else if (w_write) begin
            case (w_idx)
                REG_CUTOFF:   r_cfg.cutoff_sq <= pwdata[CFG_SQ_W-1:0];
                REG_CLOSE:    r_cfg.close_sq  <= pwdata[CFG_SQ_W-1:0];
                REG_TYPE_MAP: r_cfg.type_map  <= pwdata[TMAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_CUTOFF:   prdata = APB_DATA_W'(r_cfg.cutoff_sq);
            REG_CLOSE:    prdata = APB_DATA_W'(r_cfg.close_sq);
            REG_TYPE_MAP: prdata = APB_DATA_W'(r_cfg.type_map);
            default:      prdata = '0;
        endcase
    end

endmodule

// ----- hdl/tcnb_sqacc.sv -----
// Shared multiplier that squares the three deltas in turn and sums them.
`timescale 1ns / 1ps

module tcnb_sqacc
    import tcnb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [DELTA_W-1:0] i_dx,
    input  logic signed [DELTA_W-1:0] i_dy,
    input  logic signed [DELTA_W-1:0] i_dz,
    output logic [RSQ_W-1:0]          o_rsq,
    output logic                      o_done
);

    localparam logic [1:0] STEP_LAST = 2'd3;

    logic                        r_busy;
    logic [1:0]                  r_step;
    logic                        r_done;
    logic [PROD_W-1:0]           r_prod;
    logic [RSQ_W-1:0]            r_acc;
    logic signed [DELTA_W-1:0]   w_op;
    logic signed [2*DELTA_W-1:0] w_sq;

    // pick the delta for this step
    always_comb begin
        case (r_step)
            2'd0:    w_op = i_dx;
            2'd1:    w_op = i_dy;
            default: w_op = i_dz;
        endcase
    end

    assign w_sq   = w_op * w_op;
    assign o_rsq  = r_acc;
    assign o_done = r_done;

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == STEP_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // square into a register, then add that square to the sum on the next cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
        end else if (r_busy) begin
            r_prod <= w_sq[PROD_W-1:0];
            if (r_step != 2'd0) begin
                r_acc <= r_acc + RSQ_W'(r_prod);
            end
        end
    end

endmodule

// ----- hdl/tcnb_isqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module tcnb_isqrt
    import tcnb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [2*ROOT_W-1:0] i_radicand,
    output logic [ROOT_W-1:0]   o_root,
    output logic                o_done
);

    localparam int CNT_W = $clog2(ROOT_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [2*ROOT_W-1:0] r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [REM_W+1:0]    w_rem_sh;
    logic [REM_W+1:0]    w_trial;
    logic [REM_W+1:0]    w_diff;
    logic                w_fit;

    // bring down the next two radicand bits and try a one
    assign w_rem_sh = {r_rem, r_rad[2*ROOT_W-1 -: 2]};
    assign w_trial  = (REM_W + 2)'({r_root, 2'b01});
    assign w_diff   = w_rem_sh - w_trial;
    assign w_fit    = (w_rem_sh >= w_trial);

    assign o_root = r_root;
    assign o_done = r_done;

    // iteration count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // one restoring step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[2*ROOT_W-3:0], 2'b00};
            if (w_fit) begin
                r_rem  <= w_diff[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ----- hdl/tcnb_counts.sv -----
// Per-centre slot counters, one for each neighbour model type.
`timescale 1ns / 1ps

module tcnb_counts
    import tcnb_pkg::*;
#(
    parameter int NBR_LIMIT = 128,
    parameter int NUM_TYPES = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cnt_req i_req,
    output t_cnt_rsp o_rsp
);

    localparam logic [COUNT_W-1:0]  CNT_LIMIT  = COUNT_W'(NBR_LIMIT);
    localparam logic [TYPE_W:0]     TYPE_LIMIT = (TYPE_W + 1)'(NUM_TYPES);

    logic [COUNT_W-1:0] r_cnt [TYPE_SLOTS];
    logic [COUNT_W-1:0] w_cur;
    logic               w_grant;

    // a slot is free when the type is supported and its group not full
    assign w_cur   = r_cnt[i_req.mtype];
    assign w_grant = ({1'b0, i_req.mtype} < TYPE_LIMIT) && (w_cur < CNT_LIMIT);

    assign o_rsp.grant = w_grant;
    assign o_rsp.slot  = w_grant ? w_cur[SLOT_W-1:0] : '0;

    // clear on a new centre, advance on a granted slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            for (int t = 0; t < TYPE_SLOTS; t++) begin
                r_cnt[t] <= '0;
            end
        end else if (i_req.bump && w_grant) begin
            r_cnt[i_req.mtype] <= w_cur + 1'b1;
        end
    end

endmodule
